>>> design/free_list_allocator_macros.svh
// Assertion helpers for the free list allocator.
`ifndef FREE_LIST_ALLOCATOR_MACROS_SVH
`define FREE_LIST_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS
`define FLA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FLA_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FLA_ASSERT(lbl, clk, rst_n, prop, msg)
`define FLA_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

>>> design/fla_pkg.sv
`default_nettype none
package fla_pkg;

    localparam int DEF_ARENA_UNITS = 4096;
    localparam int DEF_UNIT_BYTES  = 16;

    localparam int CFG_W    = 13;
    localparam int CMD_W    = 2;
    localparam int NBYTES_W = 32;
    localparam int ADDR_W   = 16;
    localparam int STAT_W   = 2;
    localparam int IN_W     = 56;
    localparam int OUT_W    = 24;

    localparam logic [CFG_W-1:0] RST_HEAP_START = 13'd1;
    localparam logic [CFG_W-1:0] RST_HEAP_END   = 13'd4096;
    localparam logic [CFG_W-1:0] RST_GROW_MIN   = 13'd1024;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_ADD   = 2'd2
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_REJECT = 2'd1,
        ST_OOM    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CFG_HEAP_START = 2'd0,
        CFG_HEAP_END   = 2'd1,
        CFG_GROW_MIN   = 2'd2
    } t_cfg_idx;

endpackage
`default_nettype wire

>>> design/free_list_allocator.sv
// The list walk reads one header per cycle through the header memory's single read port.
// The block handles one transaction at a time; a new request is taken only when idle.
// Reset (synchronous, active low): no free list, rover at unit 0, break pointer at
// heap_start, registers at their reset values; header memory is not cleared.
`default_nettype none
`include "free_list_allocator_macros.svh"
module free_list_allocator #(
    parameter int ARENA_UNITS = fla_pkg::DEF_ARENA_UNITS,
    parameter int UNIT_BYTES  = fla_pkg::DEF_UNIT_BYTES
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    // command[1:0], byte_count[33:2], byte_address[49:34]
    input  wire logic [fla_pkg::IN_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    // result_address[15:0], status[17:16]
    output logic [fla_pkg::OUT_W-1:0]     m_axis_tdata,
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [1:0]               i_cfg_index,
    input  wire logic [fla_pkg::CFG_W-1:0] i_cfg_data
);
    import fla_pkg::*;

    localparam int AW    = $clog2(ARENA_UNITS);
    localparam int SW    = $clog2(2 * ARENA_UNITS);
    localparam int BW    = (SW > CFG_W) ? SW : CFG_W;
    localparam int UBS   = $clog2(UNIT_BYTES);
    localparam int LIMIT = 4 * ARENA_UNITS + 8;
    localparam int CW    = $clog2(LIMIT + 1);
    localparam logic [SW-1:0] SIZE_MASK = SW'(2 * ARENA_UNITS - 1);

    typedef struct packed {
        logic [AW-1:0] link;
        logic [SW-1:0] size;
    } t_entry;

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_A_ISSUE = 14'b00000000000010,
        S_A_PREV  = 14'b00000000000100,
        S_A_CHK   = 14'b00000000001000,
        S_A_EXACT = 14'b00000000010000,
        S_A_SPRD  = 14'b00000000100000,
        S_A_SPLIT = 14'b00000001000000,
        S_G_START = 14'b00000010000000,
        S_P_CHK   = 14'b00000100000000,
        S_F_CHK   = 14'b00001000000000,
        S_J_NX    = 14'b00010000000000,
        S_J_P     = 14'b00100000000000,
        S_G_DONE  = 14'b01000000000000,
        S_FIN     = 14'b10000000000000
    } t_state;

    typedef enum logic [1:0] {
        CTX_GROW = 2'd0,
        CTX_FREE = 2'd1,
        CTX_ADD  = 2'd2
    } t_ctx;

    t_entry mem [ARENA_UNITS];
    t_entry r_rdata;

    t_state r_state, n_state;
    t_ctx   r_ctx, n_ctx;
    logic [AW-1:0]    r_p, n_p, r_prev, n_prev, r_bp, n_bp, r_lp, n_lp, r_nbl, n_nbl;
    logic [AW-1:0]    r_rover, n_rover;
    logic [SW-1:0]    r_sp, n_sp, r_sb, n_sb, r_need, n_need;
    logic [BW-1:0]    r_chunk, n_chunk;
    logic [CW-1:0]    r_walk, n_walk, r_pcnt, n_pcnt;
    logic             r_list_ready, n_list_ready;
    logic [CFG_W-1:0] r_break, n_break, r_heap_end, r_grow_min;
    logic [ADDR_W-1:0] r_res, n_res, r_out_addr;
    t_status          r_st, n_st, r_out_st;
    logic             r_out_valid;

    logic          mem_we;
    logic [AW-1:0] mem_wa, rd_addr;
    t_entry        mem_wd;

    logic [CMD_W-1:0]    in_cmd;
    logic [NBYTES_W-1:0] in_nbytes;
    logic [ADDR_W-1:0]   in_addr, addr_units;
    logic [32:0]         need_div;
    logic [33:0]         need_full;
    logic                misal, alloc_bad, free_bad, add_bad;
    logic                in_fire, cfg_fire, out_load;

    logic          place_hit;
    logic [SW:0]   split_sum;
    logic [SW-1:0] split_size;
    logic [AW-1:0] split_q;
    logic [BW-1:0] g_need, g_min, g_chunk, g_lim, g_brk;
    logic          g_bad;
    logic [SW:0]   merge_sum;
    logic          bp_merge, p_merge;
    logic [SW-1:0] bp_size;
    logic [AW-1:0] bp_link;
    logic [31:0]   q_addr;

    assign in_cmd    = s_axis_tdata[1:0];
    assign in_nbytes = s_axis_tdata[33:2];
    assign in_addr   = s_axis_tdata[49:34];
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign cfg_fire  = i_cfg_valid && o_cfg_ready;
    assign out_load  = (r_state == S_FIN) && (!r_out_valid || m_axis_tready);

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_st, r_out_addr};

    assign need_div   = ({1'b0, in_nbytes} + 33'(UNIT_BYTES - 1)) >> UBS;
    assign need_full  = {1'b0, need_div} + 34'd1;
    assign addr_units = in_addr >> UBS;
    assign misal      = |(in_addr & ADDR_W'(UNIT_BYTES - 1));
    assign alloc_bad  = (in_nbytes == '0) || (need_full > 34'(ARENA_UNITS));
    assign free_bad   = (in_addr == '0) || misal || (addr_units < 16'd2) ||
                        ((32'(addr_units) - 32'd1) >= 32'(ARENA_UNITS));
    assign add_bad    = (in_addr == '0) || (in_nbytes == '0) || misal ||
                        ((35'(addr_units) + 35'(need_full)) > 35'(ARENA_UNITS));

    assign place_hit = ((r_bp > r_p) && (r_bp < r_rdata.link)) ||
                       ((r_p >= r_rdata.link) && ((r_bp > r_p) || (r_bp < r_rdata.link)));

    assign split_size = r_rdata.size - r_need;
    always_comb begin
        split_sum = (SW+1)'(r_p) + (SW+1)'(split_size);
        for (int i = 0; i < 4; i++) begin
            if (split_sum >= (SW+1)'(ARENA_UNITS)) begin
                split_sum = split_sum - (SW+1)'(ARENA_UNITS);
            end
        end
        split_q = split_sum[AW-1:0];
    end

    assign g_need  = BW'(r_need);
    assign g_min   = BW'(r_grow_min);
    assign g_chunk = (g_need < g_min) ? g_min : g_need;
    assign g_lim   = (BW'(r_heap_end) < BW'(ARENA_UNITS)) ? BW'(r_heap_end)
                                                          : BW'(ARENA_UNITS);
    assign g_brk   = BW'(r_break);
    assign g_bad   = (g_brk > g_lim) || (g_chunk > (g_lim - g_brk)) || (g_brk == '0);

    assign merge_sum = (SW+1)'(r_sb) + (SW+1)'(r_rdata.size);
    assign bp_merge  = ((SW+1)'(r_bp) + (SW+1)'(r_sb)) == (SW+1)'(r_lp);
    assign bp_size   = bp_merge ? (merge_sum[SW-1:0] & SIZE_MASK) : r_sb;
    assign bp_link   = bp_merge ? r_rdata.link : r_lp;
    assign p_merge   = ((SW+1)'(r_p) + (SW+1)'(r_sp)) == (SW+1)'(r_bp);

    always_comb begin
        n_state      = r_state;
        n_ctx        = r_ctx;
        n_p          = r_p;
        n_prev       = r_prev;
        n_bp         = r_bp;
        n_lp         = r_lp;
        n_nbl        = r_nbl;
        n_rover      = r_rover;
        n_sp         = r_sp;
        n_sb         = r_sb;
        n_need       = r_need;
        n_chunk      = r_chunk;
        n_walk       = r_walk;
        n_pcnt       = r_pcnt;
        n_list_ready = r_list_ready;
        n_break      = r_break;
        n_res        = r_res;
        n_st         = r_st;
        mem_we       = 1'b0;
        mem_wa       = r_p;
        mem_wd       = r_rdata;
        rd_addr      = r_rover;
        q_addr       = (32'(r_p) + 32'd1) << UBS;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_res  = '0;
                    n_st   = ST_REJECT;
                    n_walk = '0;
                    n_pcnt = '0;
                    n_p    = r_rover;
                    n_prev = r_rover;
                    n_need = need_full[SW-1:0];
                    case (in_cmd)
                        CMD_ALLOC: begin
                            if (alloc_bad) begin
                                n_state = S_FIN;
                            end else if (!r_list_ready) begin
                                mem_we       = 1'b1;
                                mem_wa       = '0;
                                mem_wd       = '0;
                                n_rover      = '0;
                                n_list_ready = 1'b1;
                                n_state      = S_A_ISSUE;
                            end else begin
                                n_state = S_A_PREV;
                            end
                        end
                        CMD_FREE: begin
                            n_bp  = AW'(addr_units - 16'd1);
                            n_ctx = CTX_FREE;
                            if (free_bad || !r_list_ready) begin
                                n_state = S_FIN;
                            end else begin
                                n_state = S_P_CHK;
                            end
                        end
                        CMD_ADD: begin
                            n_bp  = AW'(addr_units);
                            n_sb  = need_full[SW-1:0];
                            n_ctx = CTX_ADD;
                            if (add_bad) begin
                                n_state = S_FIN;
                            end else if (!r_list_ready) begin
                                mem_we       = 1'b1;
                                mem_wa       = AW'(addr_units);
                                mem_wd.link  = AW'(addr_units);
                                mem_wd.size  = need_full[SW-1:0];
                                n_rover      = AW'(addr_units);
                                n_list_ready = 1'b1;
                                n_st         = ST_OK;
                                n_state      = S_FIN;
                            end else begin
                                n_state = S_P_CHK;
                            end
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_A_ISSUE: begin
                n_prev  = r_rover;
                n_state = S_A_PREV;
            end
            S_A_PREV: begin
                n_p     = r_rdata.link;
                rd_addr = r_rdata.link;
                n_state = S_A_CHK;
            end
            S_A_CHK: begin
                n_lp = r_rdata.link;
                if (r_walk == CW'(LIMIT)) begin
                    n_st    = ST_OOM;
                    n_state = S_FIN;
                end else if (r_rdata.size >= r_need) begin
                    if (r_rdata.size == r_need) begin
                        rd_addr = r_prev;
                        n_state = S_A_EXACT;
                    end else begin
                        mem_we      = 1'b1;
                        mem_wa      = r_p;
                        mem_wd.link = r_rdata.link;
                        mem_wd.size = split_size & SIZE_MASK;
                        n_p         = split_q;
                        n_state     = S_A_SPRD;
                    end
                end else if (r_p == r_rover) begin
                    n_walk  = r_walk + CW'(1);
                    n_state = S_G_START;
                end else begin
                    n_walk  = r_walk + CW'(1);
                    n_prev  = r_p;
                    n_p     = r_rdata.link;
                    rd_addr = r_rdata.link;
                end
            end
            S_A_EXACT: begin
                mem_we      = 1'b1;
                mem_wa      = r_prev;
                mem_wd.link = r_lp;
                mem_wd.size = r_rdata.size;
                n_rover     = r_prev;
                n_res       = q_addr[ADDR_W-1:0];
                n_st        = ST_OK;
                n_state     = S_FIN;
            end
            S_A_SPRD: begin
                rd_addr = r_p;
                n_state = S_A_SPLIT;
            end
            S_A_SPLIT: begin
                mem_we      = 1'b1;
                mem_wa      = r_p;
                mem_wd.link = r_rdata.link;
                mem_wd.size = r_need;
                n_rover     = r_prev;
                n_res       = q_addr[ADDR_W-1:0];
                n_st        = ST_OK;
                n_state     = S_FIN;
            end
            S_G_START: begin
                if (g_bad) begin
                    n_st    = ST_OOM;
                    n_state = S_FIN;
                end else begin
                    n_bp    = AW'(r_break);
                    n_sb    = SW'(g_chunk) & SIZE_MASK;
                    n_chunk = g_chunk;
                    n_ctx   = CTX_GROW;
                    n_pcnt  = '0;
                    n_p     = r_rover;
                    n_state = S_P_CHK;
                end
            end
            S_P_CHK: begin
                rd_addr = r_rdata.link;
                if (r_pcnt == CW'(LIMIT)) begin
                    n_st    = (r_ctx == CTX_GROW) ? ST_OOM : ST_REJECT;
                    n_state = S_FIN;
                end else if (place_hit) begin
                    n_lp = r_rdata.link;
                    n_sp = r_rdata.size;
                    if (r_ctx == CTX_FREE) begin
                        rd_addr = r_bp;
                        n_state = S_F_CHK;
                    end else begin
                        n_state = S_J_NX;
                    end
                end else begin
                    n_p    = r_rdata.link;
                    n_pcnt = r_pcnt + CW'(1);
                end
            end
            S_F_CHK: begin
                rd_addr = r_lp;
                n_sb    = r_rdata.size;
                if (r_rdata.size == '0) begin
                    n_st    = ST_REJECT;
                    n_state = S_FIN;
                end else begin
                    n_state = S_J_NX;
                end
            end
            S_J_NX: begin
                mem_we      = 1'b1;
                mem_wa      = r_bp;
                mem_wd.link = bp_link;
                mem_wd.size = bp_size;
                n_sb        = bp_size;
                n_nbl       = bp_link;
                n_state     = S_J_P;
            end
            S_J_P: begin
                mem_we = 1'b1;
                mem_wa = r_p;
                if (p_merge) begin
                    mem_wd.link = r_nbl;
                    mem_wd.size = SW'((SW+1)'(r_sp) + (SW+1)'(r_sb)) & SIZE_MASK;
                end else begin
                    mem_wd.link = r_bp;
                    mem_wd.size = r_sp;
                end
                case (r_ctx)
                    CTX_GROW: begin
                        n_break = CFG_W'(BW'(r_break) + r_chunk);
                        n_rover = r_p;
                        n_state = S_G_DONE;
                    end
                    CTX_FREE: begin
                        n_rover = r_p;
                        n_st    = ST_OK;
                        n_state = S_FIN;
                    end
                    default: begin
                        n_st    = ST_OK;
                        n_state = S_FIN;
                    end
                endcase
            end
            S_G_DONE: begin
                n_prev  = r_rover;
                n_state = S_A_PREV;
            end
            S_FIN: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_p      <= n_p;
        r_prev   <= n_prev;
        r_bp     <= n_bp;
        r_lp     <= n_lp;
        r_nbl    <= n_nbl;
        r_sp     <= n_sp;
        r_sb     <= n_sb;
        r_need   <= n_need;
        r_chunk  <= n_chunk;
        r_res    <= n_res;
        r_st     <= n_st;
        r_ctx    <= n_ctx;
        r_walk   <= n_walk;
        r_pcnt   <= n_pcnt;
        if (out_load) begin
            r_out_addr <= r_res;
            r_out_st   <= r_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_rover      <= '0;
            r_list_ready <= 1'b0;
            r_break      <= RST_HEAP_START;
            r_heap_end   <= RST_HEAP_END;
            r_grow_min   <= RST_GROW_MIN;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_rover      <= n_rover;
            r_list_ready <= n_list_ready;
            r_break      <= n_break;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_fire) begin
                case (i_cfg_index)
                    CFG_HEAP_START: r_break    <= (i_cfg_data == '0) ? CFG_W'(1) : i_cfg_data;
                    CFG_HEAP_END:   r_heap_end <= i_cfg_data;
                    CFG_GROW_MIN:   r_grow_min <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    `FLA_ASSERT(a_busy_after_accept, i_clk, i_rst_n, in_fire |=> (r_state != S_IDLE), "accepted transaction left block idle")
    `FLA_NEVER(a_walk_bound, i_clk, i_rst_n, (r_walk > CW'(LIMIT)) || (r_pcnt > CW'(LIMIT)), "list walk counter past limit")
    `FLA_ASSERT(a_result_from_fin, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == S_FIN), "result appeared outside finish")
    `FLA_NEVER(a_list_kept, i_clk, i_rst_n, $fell(r_list_ready), "free list dropped without reset")

endmodule
`default_nettype wire

>>> tb/sv/fla_checker.sv
`timescale 1ns / 1ps
module fla_checker
    import fla_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_valid,
    input  wire logic              i_s_ready,
    input  wire logic [IN_W-1:0]   i_s_data,
    input  wire logic              i_m_valid,
    input  wire logic              i_m_ready,
    input  wire logic [OUT_W-1:0]  i_m_data,
    input  wire logic              i_cfg_valid,
    input  wire logic              i_cfg_ready,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    output int                     o_errors,
    output int                     o_pending
);
    localparam int unsigned UNITS      = DEF_ARENA_UNITS;
    localparam int unsigned UBYTES     = DEF_UNIT_BYTES;
    localparam int unsigned WALK_LIMIT = 4 * UNITS + 8;
    localparam int unsigned SIZE_MASK  = 2 * UNITS - 1;

    typedef struct packed {
        t_status     status;
        logic [15:0] addr;
    } reply_t;

    reply_t      expected_replies[$];
    logic [11:0] next_of[UNITS];
    logic [12:0] size_of[UNITS];
    logic [11:0] rover;
    bit          have_list;
    logic [12:0] brk;
    logic [12:0] heap_end_r;
    logic [12:0] grow_min_r;

    function automatic bit locate(int unsigned bp, output int unsigned where);
        int unsigned p;
        int unsigned nx;
        p = rover;
        where = 0;
        for (int n = 0; n < WALK_LIMIT; n++) begin
            nx = next_of[p];
            if ((bp > p && bp < nx) || (p >= nx && (bp > p || bp < nx))) begin
                where = p;
                return 1;
            end
            p = nx;
        end
        return 0;
    endfunction

    function automatic void splice(int unsigned bp, int unsigned p);
        int unsigned nx;
        nx = next_of[p];
        if (bp + size_of[bp] == nx) begin
            size_of[bp] = (size_of[bp] + size_of[nx]) & SIZE_MASK;
            next_of[bp] = next_of[nx];
        end else begin
            next_of[bp] = nx;
        end
        if (p + size_of[p] == bp) begin
            size_of[p] = (size_of[p] + size_of[bp]) & SIZE_MASK;
            next_of[p] = next_of[bp];
        end else begin
            next_of[p] = bp;
        end
    endfunction

    function automatic bit grow_heap(int unsigned need);
        int unsigned chunk;
        int unsigned lim;
        int unsigned bp;
        int unsigned p;
        chunk = need < grow_min_r ? grow_min_r : need;
        lim = heap_end_r < UNITS ? heap_end_r : UNITS;
        bp = brk;
        if (bp > lim || chunk > lim - bp || bp == 0) return 0;
        if (!locate(bp, p)) return 0;
        brk = bp + chunk;
        size_of[bp] = chunk & SIZE_MASK;
        splice(bp, p);
        rover = p;
        return 1;
    endfunction

    function automatic int unsigned units_for(logic [31:0] nbytes);
        longint unsigned n64;
        n64 = ({32'd0, nbytes} + 64'd15) / 64'd16 + 64'd1;
        return n64 > UNITS ? UNITS + 1 : int'(n64);
    endfunction

    function automatic t_status allocate(logic [31:0] nbytes, output logic [15:0] addr);
        int unsigned need;
        int unsigned prev;
        int unsigned p;
        addr = '0;
        if (nbytes == 0) return ST_REJECT;
        need = units_for(nbytes);
        if (need > UNITS) return ST_REJECT;
        if (!have_list) begin
            next_of[0] = '0;
            size_of[0] = '0;
            rover = '0;
            have_list = 1;
        end
        prev = rover;
        p = next_of[prev];
        for (int n = 0; n < WALK_LIMIT; n++) begin
            if (size_of[p] >= need) begin
                if (size_of[p] == need) begin
                    next_of[prev] = next_of[p];
                end else begin
                    size_of[p] = (size_of[p] - need) & SIZE_MASK;
                    p = (p + size_of[p]) % UNITS;
                    size_of[p] = need;
                end
                rover = prev;
                addr = ((p + 1) * UBYTES) & 32'hFFFF;
                return ST_OK;
            end
            if (p == rover) begin
                if (!grow_heap(need)) return ST_OOM;
                p = rover;
            end
            prev = p;
            p = next_of[p];
        end
        return ST_OOM;
    endfunction

    function automatic t_status release_block(logic [15:0] a);
        int unsigned bp;
        int unsigned p;
        if (a == 0 || a % UBYTES != 0) return ST_REJECT;
        bp = a / UBYTES;
        if (bp < 2 || bp - 1 >= UNITS) return ST_REJECT;
        bp = bp - 1;
        if (!have_list) return ST_REJECT;
        if (!locate(bp, p)) return ST_REJECT;
        if (size_of[bp] < 1) return ST_REJECT;
        splice(bp, p);
        rover = p;
        return ST_OK;
    endfunction

    function automatic t_status donate_block(logic [31:0] nbytes, logic [15:0] a);
        int unsigned bp;
        int unsigned need;
        int unsigned p;
        if (a == 0 || nbytes == 0 || a % UBYTES != 0) return ST_REJECT;
        bp = a / UBYTES;
        need = units_for(nbytes);
        if (bp + need > UNITS) return ST_REJECT;
        if (!have_list) begin
            size_of[bp] = need;
            next_of[bp] = bp;
            rover = bp;
            have_list = 1;
            return ST_OK;
        end
        if (!locate(bp, p)) return ST_REJECT;
        size_of[bp] = need;
        splice(bp, p);
        return ST_OK;
    endfunction

    function automatic reply_t predict_reply(logic [IN_W-1:0] d);
        reply_t r;
        r.addr = '0;
        case (d[1:0])
            CMD_ALLOC: r.status = allocate(d[33:2], r.addr);
            CMD_FREE:  r.status = release_block(d[49:34]);
            CMD_ADD:   r.status = donate_block(d[33:2], d[49:34]);
            default:   r.status = ST_REJECT;
        endcase
        if (r.status != ST_OK) r.addr = '0;
        return r;
    endfunction

    assign o_pending = expected_replies.size();

    always @(posedge i_clk) begin
        reply_t got;
        reply_t want;
        if (!i_rst_n) begin
            for (int i = 0; i < UNITS; i++) begin
                next_of[i] = '0;
                size_of[i] = '0;
            end
            rover = '0;
            have_list = 0;
            brk = RST_HEAP_START;
            heap_end_r = RST_HEAP_END;
            grow_min_r = RST_GROW_MIN;
            o_errors = 0;
            expected_replies.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HEAP_START: brk = i_cfg_data == 0 ? 13'd1 : i_cfg_data;
                    CFG_HEAP_END:   heap_end_r = i_cfg_data;
                    CFG_GROW_MIN:   grow_min_r = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_m_valid && i_m_ready) begin
                got = reply_t'(i_m_data[17:0]);
                if (expected_replies.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected result: addr=%h status=%0d", got.addr, got.status);
                end else begin
                    want = expected_replies.pop_front();
                    if (got.addr !== want.addr || got.status !== want.status) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("result mismatch: addr exp %h got %h, status exp %0d got %0d",
                                     want.addr, got.addr, want.status, got.status);
                    end
                end
            end
            if (i_s_valid && i_s_ready)
                expected_replies.push_back(predict_reply(i_s_data));
        end
    end
endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import fla_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int unsigned ADD_BASE  = 3072;

    logic              clk;
    logic              rst_n;
    logic              s_valid;
    logic              s_ready;
    logic [IN_W-1:0]   s_data;
    logic              m_valid;
    logic              m_ready;
    logic [OUT_W-1:0]  m_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [1:0]        cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    int                errors;
    int                pending;
    int unsigned       src_idle;
    int unsigned       dst_stall;
    int unsigned       add_next;
    logic [15:0]       live[$];

    free_list_allocator DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    fla_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_valid   (s_valid),
        .i_s_ready   (s_ready),
        .i_s_data    (s_data),
        .i_m_valid   (m_valid),
        .i_m_ready   (m_ready),
        .i_m_data    (m_data),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #(400_000_000);
        $display("Mismatches found");
        $finish;
    end

    always @(posedge clk) begin
        m_ready <= ($urandom_range(99) >= dst_stall);
        if (m_valid && m_ready && m_data[17:16] == ST_OK && m_data[15:0] != 0)
            live.push_back(m_data[15:0]);
    end

    task automatic send(logic [1:0] cmd, logic [31:0] cnt, logic [15:0] a);
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data <= {6'd0, a, cnt, cmd};
        @(posedge clk);
        while (!s_ready) @(posedge clk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic free_live();
        int unsigned k;
        logic [15:0] a;
        k = $urandom_range(live.size() - 1);
        a = live[k];
        live.delete(k);
        send(CMD_FREE, $urandom, a);
    endtask

    task automatic add_region(int unsigned nbytes);
        int unsigned need;
        need = (nbytes + 15) / 16 + 1;
        if (add_next + need <= 4096) begin
            send(CMD_ADD, nbytes, 16'(add_next * 16));
            add_next += need;
        end else begin
            send(CMD_ALLOC, $urandom_range(1, 64), $urandom);
        end
    endtask

    task automatic send_noise();
        logic [15:0] a;
        a = $urandom;
        if (a[3:0] == 0) a[0] = 1'b1;
        case ($urandom_range(5))
            0: send(CMD_UNUSED, $urandom, $urandom);
            1: send(CMD_FREE, $urandom, a);
            2: send(CMD_FREE, $urandom, 16'(16 * $urandom_range(1)));
            3: send(CMD_ADD, 32'd0, 16'((ADD_BASE + $urandom_range(900)) * 16));
            4: send(CMD_ADD, $urandom_range(1, 4096), a);
            default: send(CMD_ADD, $urandom_range(64, 900), 16'(4090 * 16));
        endcase
    endtask

    task automatic send_random();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 45 || (r < 85 && live.size() == 0)) begin
            case ($urandom_range(19))
                0:       send(CMD_ALLOC, $urandom, $urandom);
                1, 2, 3: send(CMD_ALLOC, $urandom_range(1, 2048), $urandom);
                default: send(CMD_ALLOC, $urandom_range(1, 128), $urandom);
            endcase
        end else if (r < 85) begin
            free_live();
        end else if (r < 90) begin
            add_region($urandom_range(1, 200));
        end else begin
            send_noise();
        end
    endtask

    initial begin
        rst_n <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        m_ready <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_HEAP_START;
        cfg_data <= '0;
        src_idle = 0;
        dst_stall = 0;
        add_next = ADD_BASE;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(CFG_HEAP_START, 13'd0);
        write_reg(CFG_HEAP_END, 13'd1536);
        write_reg(CFG_GROW_MIN, 13'd4096);
        send(CMD_FREE, 32'd0, 16'h0040);
        add_region(60 * 16);
        send(CMD_ALLOC, 32'd0, 16'd0);
        send(CMD_ALLOC, 32'hFFFF_FFFF, 16'hFFFF);
        send(CMD_ALLOC, 32'(4095 * 16 + 1), 16'd0);
        send(CMD_ALLOC, 32'(4095 * 16), 16'd0);
        send(CMD_ALLOC, 32'd16, 16'd0);
        send(CMD_ALLOC, 32'd1, 16'd0);
        send(CMD_FREE, 32'd0, 16'd0);
        send(CMD_FREE, 32'd0, 16'd16);
        send(CMD_FREE, 32'd0, 16'h0041);
        send(CMD_ADD, 32'd0, 16'(3500 * 16));
        send(CMD_ADD, 32'd100, 16'd0);
        send(CMD_ADD, 32'd100, 16'(3500 * 16 + 8));
        send(CMD_ADD, 32'd200, 16'(4090 * 16));
        send(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
        drain();
        while (live.size() != 0) free_live();
        drain();
        write_reg(CFG_GROW_MIN, 13'd1);
        send(CMD_ALLOC, 32'd1, 16'd0);
        send(CMD_ALLOC, 32'd48, 16'd0);
        send(CMD_ALLOC, 32'd2000, 16'd0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                1: write_reg(CFG_GROW_MIN, 13'd1024);
                2: begin
                    write_reg(CFG_HEAP_START, 13'd1536);
                    write_reg(CFG_HEAP_END, 13'd3072);
                    write_reg(CFG_GROW_MIN, 13'd64);
                end
                3: write_reg(CFG_GROW_MIN, 13'd4096);
                4: begin
                    write_reg(CFG_HEAP_START, 13'd4096);
                    write_reg(CFG_HEAP_END, 13'd4096);
                    write_reg(CFG_GROW_MIN, 13'd1);
                end
                5: write_reg(CFG_HEAP_END, 13'd1);
                default: ;
            endcase
            for (int k = 0; k < 305; k++) begin
                if (k % 75 == 0) begin
                    case ((k / 75 + ph) % 4)
                        0: begin src_idle = 0;  dst_stall = 0;  end
                        1: begin src_idle = 53; dst_stall = 0;  end
                        2: begin src_idle = 0;  dst_stall = 53; end
                        default: begin src_idle = 26; dst_stall = 26; end
                    endcase
                end
                send_random();
            end
            drain();
        end

        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
